### rtl/core/wmhe_pkg.sv
// Shared constants, types and helpers for the 802.11 MAC header extractor.
package wmhe_pkg;

  localparam int LENGTH_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  localparam int DATA_W = 320;

  localparam logic [1:0] VERSION_ZERO = 2'd0;
  localparam logic [1:0] TYPE_MGMT = 2'd0;
  localparam logic [1:0] TYPE_CTRL = 2'd1;
  localparam logic [1:0] TYPE_DATA = 2'd2;

  localparam logic [3:0] SUB_MGMT_MAX = 4'd12;
  localparam logic [3:0] SUB_CTRL_MIN = 4'd8;
  localparam logic [3:0] SUB_DATA_MAX = 4'd8;
  localparam logic [3:0] SUB_QOS_DATA = 4'd8;

  // Distribution bits: bit 0 is ToDS, bit 1 is FromDS.
  localparam logic [1:0] DS_NONE = 2'd0;
  localparam logic [1:0] DS_FROM = 2'd2;

  localparam int unsigned RADIOTAP_MIN   = 8;
  localparam int unsigned HDR_MIN        = 24;
  localparam int unsigned HDR_QOS_END    = 26;
  localparam int unsigned HDR_STAMP_END  = 32;
  localparam int unsigned HDR_INTVL_END  = 34;
  localparam int unsigned HDR_CAPAB_END  = 36;
  localparam int unsigned CAPTURE_SAT    = 32'h0000_FFFF;

  typedef struct packed {
    logic        accepted;
    logic [15:0] frame_ctrl;
    logic [15:0] duration_id;
    logic [47:0] destination_address;
    logic [47:0] source_address;
    logic [47:0] bss_identifier;
    logic [11:0] seq_num;
    logic [63:0] beacon_timestamp;
    logic [15:0] beacon_period;
    logic [15:0] capab_bits;
    logic [15:0] qos_ctrl;
    logic [15:0] capture_length;
  } result_t;

  function automatic logic subtype_ok(input logic [1:0] ftype, input logic [3:0] sub);
    logic ok;
    ok = 1'b0;
    unique case (ftype)
      TYPE_MGMT: ok = (sub <= SUB_MGMT_MAX);
      TYPE_CTRL: ok = (sub >= SUB_CTRL_MIN);
      TYPE_DATA: ok = (sub <= SUB_DATA_MAX);
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

### rtl/core/wlan_mac_header_extractor_top.sv
// Top level of the 802.11 MAC header extractor: byte capture, checks and result buffer.
// The result of a capture is registered into the result buffer as its last byte is accepted.
// Throughput: one byte per cycle; a two-entry result buffer keeps input flowing while a
// result waits, so input stalls only when both result entries are held.
// Reset: synchronous, active high; clears the mode register, all capture state and the
// result buffer.
module wlan_mac_header_extractor_top
  import wmhe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // data_byte
  input  logic              s_tlast,   // last_byte
  output logic              m_tvalid,
  input  logic              m_tready,
  // frame_ctrl, duration_id, destination_address, source_address, bss_identifier,
  // seq_num, beacon_timestamp, beacon_period, capab_bits, qos_ctrl,
  // capture_length, then zero padding
  output logic [DATA_W-1:0] m_tdata,
  output logic              m_tuser,   // accepted
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data   // radiotap_mode
);

  logic                   radiotap_mode;
  logic                   frame_mode, frame_mode_next;
  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;
  logic [15:0]            header_skip, header_skip_next;
  logic [23:0]            prefix_bytes, prefix_bytes_next;
  logic [15:0]            control_word, control_word_next;
  logic [15:0]            duration_word, duration_word_next;
  logic [47:0]            address_one, address_one_next;
  logic [47:0]            address_two, address_two_next;
  logic [47:0]            address_three, address_three_next;
  logic [15:0]            sequence_word, sequence_word_next;
  logic [63:0]            timestamp_word, timestamp_word_next;
  logic [15:0]            interval_word, interval_word_next;
  logic [15:0]            capability_word, capability_word_next;
  logic [15:0]            qos_word, qos_word_next;

  logic    out_valid, skid_valid;
  result_t out_res, skid_res, res;
  logic    in_fire, res_fire, out_pop;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign in_fire   = s_tvalid && s_tready;
  assign res_fire  = in_fire && s_tlast;
  assign out_pop   = out_valid && m_tready;

  always_comb begin
    logic                   mode;
    logic                   gen_en;
    logic [31:0]            rel;
    logic [5:0]             r;
    logic [7:0]             b;
    logic [31:0]            pb;
    logic [31:0]            total, skip, hlen;
    logic [1:0]             ftype, ds;
    logic [3:0]             sub;
    logic                   ok;

    b    = s_tdata;
    mode = (byte_count == '0) ? radiotap_mode : frame_mode;

    frame_mode_next      = mode;
    byte_count_next      = byte_count;
    header_skip_next     = header_skip;
    prefix_bytes_next    = prefix_bytes;
    control_word_next    = control_word;
    duration_word_next   = duration_word;
    address_one_next     = address_one;
    address_two_next     = address_two;
    address_three_next   = address_three;
    sequence_word_next   = sequence_word;
    timestamp_word_next  = timestamp_word;
    interval_word_next   = interval_word;
    capability_word_next = capability_word;
    qos_word_next        = qos_word;

    gen_en = 1'b0;
    rel    = 32'(byte_count);
    pb     = {b, prefix_bytes};

    if (byte_count < COUNT_MAX) begin
      if (byte_count < LENGTH_BITS'(3)) begin
        prefix_bytes_next[8*byte_count[1:0] +: 8] = b;
      end
      if (!mode) begin
        gen_en = 1'b1;
      end else if (byte_count == LENGTH_BITS'(3)) begin
        // Radiotap length is complete; bytes already held start the MAC header if it is short.
        header_skip_next = pb[31:16];
        for (int k = 0; k < 4; k++) begin
          if (pb[31:16] <= 16'd3 && (k + int'(pb[17:16])) <= 3) begin
            if (k < 2) begin
              control_word_next[8*k +: 8] = control_word_next[8*k +: 8] |
                                            pb[8*(k + int'(pb[17:16])) +: 8];
            end else begin
              duration_word_next[8*(k-2) +: 8] = duration_word_next[8*(k-2) +: 8] |
                                                 pb[8*(k + int'(pb[17:16])) +: 8];
            end
          end
        end
      end else if (byte_count > LENGTH_BITS'(3) &&
                   32'(byte_count) >= 32'(header_skip)) begin
        gen_en = 1'b1;
        rel    = 32'(byte_count) - 32'(header_skip);
      end
      byte_count_next = LENGTH_BITS'(32'(byte_count) + 32'd1);
    end

    r = rel[5:0];
    if (gen_en && rel < 32'(HDR_CAPAB_END)) begin
      if (r < 6'd2) begin
        control_word_next[8*r +: 8] = control_word_next[8*r +: 8] | b;
      end else if (r < 6'd4) begin
        duration_word_next[8*(r-6'd2) +: 8] = duration_word_next[8*(r-6'd2) +: 8] | b;
      end else if (r < 6'd10) begin
        address_one_next[8*(6'd9-r) +: 8] = address_one_next[8*(6'd9-r) +: 8] | b;
      end else if (r < 6'd16) begin
        address_two_next[8*(6'd15-r) +: 8] = address_two_next[8*(6'd15-r) +: 8] | b;
      end else if (r < 6'd22) begin
        address_three_next[8*(6'd21-r) +: 8] = address_three_next[8*(6'd21-r) +: 8] | b;
      end else if (r < 6'd24) begin
        sequence_word_next[8*(r-6'd22) +: 8] = sequence_word_next[8*(r-6'd22) +: 8] | b;
      end else if (r < 6'd32) begin
        timestamp_word_next[8*(r-6'd24) +: 8] = timestamp_word_next[8*(r-6'd24) +: 8] | b;
        if (r < 6'd26) begin
          qos_word_next[8*(r-6'd24) +: 8] = qos_word_next[8*(r-6'd24) +: 8] | b;
        end
      end else if (r < 6'd34) begin
        interval_word_next[8*(r-6'd32) +: 8] = interval_word_next[8*(r-6'd32) +: 8] | b;
      end else begin
        capability_word_next[8*(r-6'd34) +: 8] = capability_word_next[8*(r-6'd34) +: 8] | b;
      end
    end

    // Checks and field selection on the state as it stands after this byte.
    total = 32'(byte_count_next);
    skip  = mode ? 32'(header_skip_next) : 32'd0;
    hlen  = (total > skip) ? (total - skip) : 32'd0;
    ftype = control_word_next[3:2];
    sub   = control_word_next[7:4];
    ds    = control_word_next[9:8];
    ok    = 1'b1;
    if (mode && (total < 32'(RADIOTAP_MIN) || skip >= total)) ok = 1'b0;
    if (hlen < 32'(HDR_MIN)) ok = 1'b0;
    if (control_word_next[1:0] != VERSION_ZERO) ok = 1'b0;
    if (!subtype_ok(ftype, sub)) ok = 1'b0;

    res = '0;
    if (ok) begin
      res.accepted    = 1'b1;
      res.frame_ctrl  = control_word_next;
      res.duration_id = duration_word_next;
      case (ds)
        DS_NONE: begin
          res.destination_address = address_one_next;
          res.source_address      = address_two_next;
          res.bss_identifier      = address_three_next;
        end
        DS_FROM: begin
          res.destination_address = address_one_next;
          res.source_address      = address_three_next;
          res.bss_identifier      = address_two_next;
        end
        default: begin
          res.destination_address = address_three_next;
          res.source_address      = address_two_next;
          res.bss_identifier      = address_one_next;
        end
      endcase
      res.seq_num = sequence_word_next[11:0];
      if (ftype == TYPE_MGMT) begin
        if (hlen >= 32'(HDR_STAMP_END)) res.beacon_timestamp = timestamp_word_next;
        if (hlen >= 32'(HDR_INTVL_END)) res.beacon_period    = interval_word_next;
        if (hlen >= 32'(HDR_CAPAB_END)) res.capab_bits       = capability_word_next;
      end
      if (ftype == TYPE_DATA && sub == SUB_QOS_DATA && hlen >= 32'(HDR_QOS_END)) begin
        res.qos_ctrl = qos_word_next;
      end
      res.capture_length = (total > CAPTURE_SAT) ? 16'hFFFF : 16'(total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radiotap_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      radiotap_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || res_fire) begin
      frame_mode      <= 1'b0;
      byte_count      <= '0;
      header_skip     <= '0;
      prefix_bytes    <= '0;
      control_word    <= '0;
      duration_word   <= '0;
      address_one     <= '0;
      address_two     <= '0;
      address_three   <= '0;
      sequence_word   <= '0;
      timestamp_word  <= '0;
      interval_word   <= '0;
      capability_word <= '0;
      qos_word        <= '0;
    end else if (in_fire) begin
      frame_mode      <= frame_mode_next;
      byte_count      <= byte_count_next;
      header_skip     <= header_skip_next;
      prefix_bytes    <= prefix_bytes_next;
      control_word    <= control_word_next;
      duration_word   <= duration_word_next;
      address_one     <= address_one_next;
      address_two     <= address_two_next;
      address_three   <= address_three_next;
      sequence_word   <= sequence_word_next;
      timestamp_word  <= timestamp_word_next;
      interval_word   <= interval_word_next;
      capability_word <= capability_word_next;
      qos_word        <= qos_word_next;
    end
  end

  // Two-entry result buffer: the skid entry catches a result while the output is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_pop) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (res_fire) begin
        out_res <= res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.accepted;
  assign m_tdata  = {4'b0000,
                     out_res.capture_length,
                     out_res.qos_ctrl,
                     out_res.capab_bits,
                     out_res.beacon_period,
                     out_res.beacon_timestamp,
                     out_res.seq_num,
                     out_res.bss_identifier,
                     out_res.source_address,
                     out_res.destination_address,
                     out_res.duration_id,
                     out_res.frame_ctrl};

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid entry held while the output entry is empty.");

  a_reject_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tuser) |-> (m_tdata == '0))
    else $error("Rejected frame carries non-zero fields.");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> (byte_count == '0 && control_word == '0 && header_skip == '0))
    else $error("Capture state not cleared after the final byte.");

  a_result_enters: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> out_valid)
    else $error("Final byte accepted but no result is presented.");

endmodule
